// ----- sv/ris_pkg.sv -----
// ============================================================================
// ris_pkg
// Shared constants, codes and types of the inode slot table.
// ============================================================================
package ris_pkg;

    localparam int TABLE_SLOTS     = 64;
    localparam int INODES_IN_BLOCK = 64;
    localparam int INODE_BYTES     = 64;

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    // floor(inode / INODES_IN_BLOCK) = (inode * DIV_MUL) >> DIV_SH for 16-bit inodes
    localparam int     DIV_SH    = 16 + $clog2(INODES_IN_BLOCK);
    localparam longint DIV_MUL_L = ((longint'(1) << DIV_SH) + INODES_IN_BLOCK - 1)
                                   / INODES_IN_BLOCK;
    localparam logic [16:0] DIV_MUL     = 17'(DIV_MUL_L);
    localparam logic [8:0]  DIV_K       = 9'(INODES_IN_BLOCK);
    localparam logic [8:0]  INO_BYTES_K = 9'(INODE_BYTES);

    localparam logic [1:0] OP_GET   = 2'd0;
    localparam logic [1:0] OP_PUT   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_HIT        = 3'd0;
    localparam logic [2:0] ST_LOAD       = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_PUT_UNUSED = 3'd3;
    localparam logic [2:0] ST_PUT_HELD   = 3'd4;
    localparam logic [2:0] ST_WRITEBACK  = 3'd5;
    localparam logic [2:0] ST_CLEARED    = 3'd6;
    localparam logic [2:0] ST_SATURATED  = 3'd7;

    localparam logic [7:0] CNT_MAX = 8'hFF;

    // search item travelling down the cell row
    typedef struct packed {
        logic              vld;
        logic [1:0]        op;
        logic [15:0]       inode;
        logic [5:0]        sel;
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic [7:0]        hit_cnt;
        logic              free;
        logic [SLOT_W-1:0] free_idx;
        logic [7:0]        sel_cnt;
        logic [15:0]       sel_inode;
    } tok_t;

    // update broadcast to all cells
    typedef struct packed {
        logic              en;
        logic              clr_all;
        logic [SLOT_W-1:0] idx;
        logic              ld_inode;
        logic [15:0]       inode;
        logic [7:0]        cnt;
    } wr_t;

    function automatic logic [5:0] slot6(input logic [SLOT_W-1:0] i);
        logic [8:0] w;
        w = 9'(i);
        return w[5:0];
    endfunction

endpackage

// ----- sv/ris_cell.sv -----
// ============================================================================
// ris_cell
// One table slot: holds inode and count, updates the passing search item.
// ============================================================================
module ris_cell
    import ris_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] cell_index,
    input  tok_t              tok_in,
    input  wr_t               wr,
    output tok_t              tok_out
);

    logic [7:0]  cnt_reg;
    logic [15:0] inode_reg;
    logic        vld_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        held;

    assign held = (cnt_reg != 8'd0);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.op == OP_GET)
        begin
            if (!tok_in.hit && held && (inode_reg == tok_in.inode))
            begin
                tok_next.hit     = 1'b1;
                tok_next.hit_idx = cell_index;
                tok_next.hit_cnt = cnt_reg;
            end
            if (!tok_in.free && !held)
            begin
                tok_next.free     = 1'b1;
                tok_next.free_idx = cell_index;
            end
        end
        else if (9'(tok_in.sel) == 9'(cell_index))
        begin
            tok_next.sel_cnt   = cnt_reg;
            tok_next.sel_inode = inode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 8'd0;
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= tok_in.vld;
            if (wr.clr_all)
            begin
                cnt_reg <= 8'd0;
            end
            else if (wr.en && (wr.idx == cell_index))
            begin
                cnt_reg <= wr.cnt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (!wr.clr_all && wr.en && wr.ld_inode && (wr.idx == cell_index))
        begin
            inode_reg <= wr.inode;
        end
    end

    // valid comes from the reset flop, the rest of the item from tok_reg
    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.vld = vld_reg;
    end

endmodule

// ----- sv/ris_locate.sv -----
// ============================================================================
// ris_locate
// Four-stage unit: disk block and byte offset of an inode.
// ============================================================================
module ris_locate
    import ris_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] inode,
    input  logic [15:0] base,
    output logic        done,
    output logic [15:0] block,
    output logic [11:0] offset
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [15:0] ino1_reg, ino2_reg;
    logic [15:0] base1_reg, base2_reg, base3_reg;
    logic [40:0] prod1_reg;
    logic [15:0] q_w;
    logic [15:0] q2_reg, q3_reg;
    logic [24:0] qd2_reg;
    logic [16:0] r_ext;
    logic [7:0]  r3_reg;
    logic [16:0] off_prod;
    logic [15:0] block_reg;
    logic [11:0] off_reg;

    assign q_w      = prod1_reg[DIV_SH +: 16];
    assign r_ext    = 17'(ino2_reg) - qd2_reg[16:0];
    assign off_prod = 17'(r3_reg) * 17'(INO_BYTES_K);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ino1_reg  <= inode;
        base1_reg <= base;
        prod1_reg <= 41'(inode) * 41'(DIV_MUL);

        ino2_reg  <= ino1_reg;
        base2_reg <= base1_reg;
        q2_reg    <= q_w;
        qd2_reg   <= 25'(q_w) * 25'(DIV_K);

        base3_reg <= base2_reg;
        if (r_ext >= 17'(DIV_K))
        begin
            q3_reg <= q2_reg + 16'd1;
            r3_reg <= 8'(r_ext - 17'(DIV_K));
        end
        else
        begin
            q3_reg <= q2_reg;
            r3_reg <= 8'(r_ext);
        end

        block_reg <= base3_reg + q3_reg;
        off_reg   <= off_prod[11:0];
    end

    assign done   = v4_reg;
    assign block  = block_reg;
    assign offset = off_reg;

endmodule

// ----- sv/refcounted_inode_slot_table.sv -----
// ============================================================================
// refcounted_inode_slot_table
// Reference-counted table of open inode slots built as a row of slot cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): operation, inode_number, slot_index.
// Output channel (out_valid/out_stall): status, slot, count_after,
// disk_block, byte_offset. An item moves when valid is high and stall low.
// A get or put sends a search item down the row of TABLE_SLOTS cells, one
// cell per cycle. A load or write-back then also passes through the locate
// unit (multiply by reciprocal, correction, offset). The result then goes
// through the result registers into the output register. Operation 3 is
// dropped with no result. One item is in work at a time; in_stall is high
// until the result reaches the output register, which may still hold the
// prior result while the next item is searched.
// Reset empties every slot and sets first_inode_block to 3. A stalled
// result holds in the output register; the next item can still be searched.
// first_inode_block sits at APB address 0.
// ============================================================================
module refcounted_inode_slot_table
    import ris_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] inode_number,
    input  logic [5:0]  slot_index,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [5:0]  slot,
    output logic [7:0]  count_after,
    output logic [15:0] disk_block,
    output logic [11:0] byte_offset
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LOC  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [15:0] first_blk_reg;

    logic        in_acc;
    tok_t        head_tok;
    tok_t        chain [TABLE_SLOTS+1];
    tok_t        tail;
    wr_t         wr;

    logic [2:0]  res_status_reg, res_status_next;
    logic [5:0]  res_slot_reg, res_slot_next;
    logic [7:0]  res_cnt_reg, res_cnt_next;
    logic [15:0] res_blk_reg;
    logic [11:0] res_off_reg;
    logic        clr_loc;

    logic        loc_start;
    logic [15:0] loc_inode;
    logic        loc_done;
    logic [15:0] loc_block;
    logic [11:0] loc_offset;

    logic        out_valid_reg;
    logic        out_load;
    logic [2:0]  status_reg;
    logic [5:0]  slot_reg;
    logic [7:0]  count_reg;
    logic [15:0] block_reg;
    logic [11:0] offset_reg;
    logic [7:0]  cnt_dec;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? 32'(first_blk_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_blk_reg <= 16'd3;
        end
        else if (psel && penable && pwrite && (paddr == 1'b0))
        begin
            first_blk_reg <= pwdata[15:0];
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        head_tok       = '0;
        head_tok.vld   = in_acc && ((operation == OP_GET) || (operation == OP_PUT));
        head_tok.op    = operation;
        head_tok.inode = inode_number;
        head_tok.sel   = slot_index;
    end

    assign chain[0] = head_tok;

    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_cell
        ris_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (SLOT_W'(i)),
            .tok_in     (chain[i]),
            .wr         (wr),
            .tok_out    (chain[i+1])
        );
    end

    assign tail    = chain[TABLE_SLOTS];
    assign cnt_dec = tail.sel_cnt - 8'd1;

    // state machine: clear-all, decision when the search item leaves the row, locate wait, output load
    always_comb
    begin
        state_next      = state_reg;
        wr              = '0;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_cnt_next    = res_cnt_reg;
        loc_start       = 1'b0;
        loc_inode       = tail.inode;
        clr_loc         = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if ((operation == OP_GET) || (operation == OP_PUT))
                    begin
                        state_next = S_SCAN;
                    end
                    else if (operation == OP_CLEAR)
                    begin
                        wr.clr_all      = 1'b1;
                        res_status_next = ST_CLEARED;
                        res_slot_next   = 6'd0;
                        res_cnt_next    = 8'd0;
                        clr_loc         = 1'b1;
                        state_next      = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (tail.vld)
                begin
                    state_next = S_DONE;
                    clr_loc    = 1'b1;
                    if (tail.op == OP_GET)
                    begin
                        if (tail.hit)
                        begin
                            res_slot_next = slot6(tail.hit_idx);
                            if (tail.hit_cnt == CNT_MAX)
                            begin
                                res_status_next = ST_SATURATED;
                                res_cnt_next    = CNT_MAX;
                            end
                            else
                            begin
                                wr.en           = 1'b1;
                                wr.idx          = tail.hit_idx;
                                wr.cnt          = tail.hit_cnt + 8'd1;
                                res_status_next = ST_HIT;
                                res_cnt_next    = tail.hit_cnt + 8'd1;
                            end
                        end
                        else if (tail.free)
                        begin
                            wr.en           = 1'b1;
                            wr.idx          = tail.free_idx;
                            wr.ld_inode     = 1'b1;
                            wr.inode        = tail.inode;
                            wr.cnt          = 8'd1;
                            res_status_next = ST_LOAD;
                            res_slot_next   = slot6(tail.free_idx);
                            res_cnt_next    = 8'd1;
                            loc_start       = 1'b1;
                            loc_inode       = tail.inode;
                            state_next      = S_LOC;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                            res_slot_next   = 6'd0;
                            res_cnt_next    = 8'd0;
                        end
                    end
                    else
                    begin
                        res_slot_next = tail.sel;
                        if (tail.sel_cnt == 8'd0)
                        begin
                            res_status_next = ST_PUT_UNUSED;
                            res_cnt_next    = 8'd0;
                        end
                        else
                        begin
                            wr.en        = 1'b1;
                            wr.idx       = SLOT_W'(tail.sel);
                            wr.cnt       = cnt_dec;
                            res_cnt_next = cnt_dec;
                            if (cnt_dec == 8'd0)
                            begin
                                res_status_next = ST_WRITEBACK;
                                loc_start       = 1'b1;
                                loc_inode       = tail.sel_inode;
                                state_next      = S_LOC;
                            end
                            else
                            begin
                                res_status_next = ST_PUT_HELD;
                            end
                        end
                    end
                end
            end
            S_LOC:
            begin
                if (loc_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    ris_locate u_locate (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (loc_start),
        .inode  (loc_inode),
        .base   (first_blk_reg),
        .done   (loc_done),
        .block  (loc_block),
        .offset (loc_offset)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_cnt_reg    <= res_cnt_next;
        if (clr_loc)
        begin
            res_blk_reg <= 16'd0;
            res_off_reg <= 12'd0;
        end
        else if (loc_done)
        begin
            res_blk_reg <= loc_block;
            res_off_reg <= loc_offset;
        end
        if (out_load)
        begin
            status_reg <= res_status_reg;
            slot_reg   <= res_slot_reg;
            count_reg  <= res_cnt_reg;
            block_reg  <= res_blk_reg;
            offset_reg <= res_off_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign count_after = count_reg;
    assign disk_block  = block_reg;
    assign byte_offset = offset_reg;

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.vld |-> (state_reg == S_SCAN))
        else $error("search item left the row outside the scan");

    a_loc_done_in_loc: assert property (@(posedge clk) disable iff (!rst_n)
        loc_done |-> (state_reg == S_LOC))
        else $error("locate unit finished outside the locate wait");

    a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && ((operation == OP_GET) || (operation == OP_PUT))) |=>
        (state_reg == S_SCAN))
        else $error("accepted get or put did not start a scan");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result shown without a finished item");

endmodule

// ----- bench/refcounted_inode_slot_table_checker.sv -----
// ============================================================================
// refcounted_inode_slot_table_checker
// Watches the config port and both item channels of the inode slot table,
// keeps its own copy of the slot table and the inode area base, predicts the
// reply to every accepted request that has one and compares each reply, field
// by field, with the oldest prediction. Hands the mismatch count and the number of
// replies still awaited to the testbench top.
// ============================================================================
module refcounted_inode_slot_table_checker
    import ris_pkg::*;
#(
    parameter logic [0:0] FIRST_BLOCK_ADDR = 1'b0
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] inode_number,
    input  logic [5:0]  slot_index,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [5:0]  slot,
    input  logic [7:0]  count_after,
    input  logic [15:0] disk_block,
    input  logic [11:0] byte_offset,

    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] FIRST_BLOCK_RESET = 16'd3;
    localparam int          MAX_REPORTS       = 200;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [7:0]  count;
        logic [15:0] block;
        logic [11:0] offset;
    } slot_reply_t;

    logic [15:0] held_inode [TABLE_SLOTS];
    logic [7:0]  held_count [TABLE_SLOTS];
    logic [15:0] inode_area_base;
    slot_reply_t awaited_replies [$];
    int          fault_count;

    task automatic report_mismatch(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t ns checker: %s", $time, msg);
    endtask

    function automatic void locate_inode(input logic [15:0] ino, output logic [15:0] blk,
                                         output logic [11:0] off);
        blk = 16'(inode_area_base + ino / INODES_IN_BLOCK);
        off = 12'((ino % INODES_IN_BLOCK) * INODE_BYTES);
    endfunction

    // Applies one request to the table copy; returns 0 when no reply follows.
    function automatic bit table_step(input logic [1:0] op, input logic [15:0] ino,
                                      input logic [5:0] idx, output slot_reply_t r);
        int i;
        r = '0;
        case (op)
            OP_GET:
            begin
                for (i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (held_count[i] != 0 && held_inode[i] == ino)
                    begin
                        r.slot = 6'(i);
                        if (held_count[i] == CNT_MAX)
                        begin
                            r.status = ST_SATURATED;
                            r.count  = CNT_MAX;
                        end
                        else
                        begin
                            held_count[i] = held_count[i] + 8'd1;
                            r.status      = ST_HIT;
                            r.count       = held_count[i];
                        end
                        return 1'b1;
                    end
                end
                for (i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (held_count[i] == 0)
                    begin
                        held_inode[i] = ino;
                        held_count[i] = 8'd1;
                        r.status      = ST_LOAD;
                        r.slot        = 6'(i);
                        r.count       = 8'd1;
                        locate_inode(ino, r.block, r.offset);
                        return 1'b1;
                    end
                end
                r.status = ST_FULL;
                return 1'b1;
            end
            OP_PUT:
            begin
                r.slot = idx;
                if (int'(idx) >= TABLE_SLOTS || held_count[idx] == 0)
                begin
                    r.status = ST_PUT_UNUSED;
                    return 1'b1;
                end
                held_count[idx] = held_count[idx] - 8'd1;
                r.count         = held_count[idx];
                if (held_count[idx] == 0)
                begin
                    r.status = ST_WRITEBACK;
                    locate_inode(held_inode[idx], r.block, r.offset);
                end
                else
                    r.status = ST_PUT_HELD;
                return 1'b1;
            end
            OP_CLEAR:
            begin
                for (i = 0; i < TABLE_SLOTS; i++)
                    held_count[i] = '0;
                r.status = ST_CLEARED;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slot_reply_t seen;
        slot_reply_t want;
        if (!rst_n)
        begin
            held_inode      = '{default: '0};
            held_count      = '{default: '0};
            inode_area_base = FIRST_BLOCK_RESET;
            awaited_replies.delete();
            fault_count     = 0;
            mismatches     <= 0;
            pending        <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{status, slot, count_after, disk_block, byte_offset};
                if (awaited_replies.size() == 0)
                    report_mismatch($sformatf("reply with none awaited: status %0d slot %0d",
                                              seen.status, seen.slot));
                else
                begin
                    want = awaited_replies.pop_front();
                    if (seen.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  seen.status, want.status));
                    if (seen.slot !== want.slot)
                        report_mismatch($sformatf("slot got %0d expected %0d",
                                                  seen.slot, want.slot));
                    if (seen.count !== want.count)
                        report_mismatch($sformatf("count_after got %0d expected %0d",
                                                  seen.count, want.count));
                    if (seen.block !== want.block)
                        report_mismatch($sformatf("disk_block got %0h expected %0h",
                                                  seen.block, want.block));
                    if (seen.offset !== want.offset)
                        report_mismatch($sformatf("byte_offset got %0h expected %0h",
                                                  seen.offset, want.offset));
                end
            end
            if (psel && penable && pwrite && pready && paddr == FIRST_BLOCK_ADDR)
                inode_area_base = pwdata[15:0];
            if (in_valid && !in_stall)
            begin
                if (table_step(operation, inode_number, slot_index, want))
                    awaited_replies.push_back(want);
            end
            mismatches <= fault_count;
            pending    <= awaited_replies.size();
        end
    end

endmodule

// ----- bench/tb_refcounted_inode_slot_table.sv -----
// ============================================================================
// tb_refcounted_inode_slot_table
// Stimulus and verdict for the inode slot table.
// ----------------------------------------------------------------------------
// Runs several inode area base settings, including both extremes. Opens with
// a short directed list of corners, then per setting a table-fill or
// count-saturation run where planned and a stretch of mixed get/put/clear
// traffic, with some unused operations, over a small inode pool. Sender gaps
// and receiver stalls are drawn per item, with stall-free stretches and one
// long output hold-off. The checker instance predicts and compares every reply.
// ============================================================================
module tb_refcounted_inode_slot_table;
    timeunit 1ns;
    timeprecision 1ps;

    import ris_pkg::*;

    localparam logic [1:0] OP_UNUSED        = 2'd3;
    localparam logic [0:0] FIRST_BLOCK_ADDR = 1'b0;
    localparam int         MAX_GAP          = 12;
    localparam int         LONG_HOLD        = 600;
    localparam int         SETTLE_CYCLES    = 120;
    localparam int         WATCHDOG_LIMIT   = 4000;
    localparam int         PHASES           = 6;
    localparam int         MIX_ITEMS        = 240;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [15:0] inode_number;
    logic [5:0]  slot_index;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [7:0]  count_after;
    logic [15:0] disk_block;
    logic [11:0] byte_offset;

    int          mismatches;
    int          pending;
    int          idle_cycles;
    int          items_sent;
    int          results_taken;
    bit          burst;
    logic        long_hold;

    refcounted_inode_slot_table u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .inode_number (inode_number),
        .slot_index   (slot_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .slot         (slot),
        .count_after  (count_after),
        .disk_block   (disk_block),
        .byte_offset  (byte_offset)
    );

    refcounted_inode_slot_table_checker #(
        .FIRST_BLOCK_ADDR (FIRST_BLOCK_ADDR)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .inode_number (inode_number),
        .slot_index   (slot_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .slot         (slot),
        .count_after  (count_after),
        .disk_block   (disk_block),
        .byte_offset  (byte_offset),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns watchdog: no item moved for %0d cycles", $time, idle_cycles);
            $display("tb_refcounted_inode_slot_table: done, errors");
            $finish;
        end
    end

    task automatic offer_request(input logic [1:0] op, input logic [15:0] ino,
                                 input logic [5:0] idx);
        int gap;
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        inode_number <= ino;
        slot_index   <= idx;
        do @(posedge clk); while (in_stall);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic offer_get(input logic [15:0] ino);
        offer_request(OP_GET, ino, 6'($urandom));
    endtask

    task automatic offer_put(input logic [5:0] idx);
        offer_request(OP_PUT, 16'($urandom), idx);
    endtask

    task automatic offer_clear();
        offer_request(OP_CLEAR, 16'($urandom), 6'($urandom));
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_first_block(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FIRST_BLOCK_ADDR;
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // distinct inodes until the table is full, then full, hit, put and load cases
    task automatic fill_slot_table();
        logic [15:0] base;
        int          k;
        base = 16'($urandom);
        offer_clear();
        for (k = 0; k < TABLE_SLOTS + 2; k++)
            offer_get(base + 16'(k * 1031));
        offer_get(base);
        offer_put(6'd37);
        offer_put(6'($urandom_range(0, TABLE_SLOTS - 1)));
        offer_get(base + 16'd7);
        offer_get(16'($urandom));
    endtask

    task automatic mixed_traffic(input int n);
        logic [15:0] inode_pool [16];
        int          k;
        int          r;
        for (k = 0; k < 16; k++)
            inode_pool[k] = 16'($urandom);
        inode_pool[0] = 16'h0000;
        inode_pool[1] = 16'hFFFF;
        for (k = 0; k < n; k++)
        begin
            if (k % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 55)
                offer_get(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : inode_pool[$urandom_range(0, 15)]);
            else if (r < 95)
                offer_put(($urandom_range(0, 4) == 0) ? 6'($urandom)
                                                      : 6'($urandom_range(0, 15)));
            else if (r < 98)
                offer_clear();
            else
                offer_request(OP_UNUSED, 16'($urandom), 6'($urandom));
        end
        burst = 1'b0;
    endtask

    initial
    begin : receiver
        int n;
        bit quiet;
        bit held_once;
        quiet         = 1'b0;
        held_once     = 1'b0;
        results_taken = 0;
        out_stall     = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (results_taken % 32 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            n = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (long_hold && !held_once)
            begin
                n         = LONG_HOLD;
                held_once = 1'b1;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            results_taken++;
        end
    end

    initial
    begin : stimulus
        int          ph;
        int          k;
        logic [15:0] setting;
        logic [15:0] ino;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        operation    = OP_GET;
        inode_number = '0;
        slot_index   = '0;
        idle_cycles  = 0;
        items_sent   = 0;
        burst        = 1'b0;
        long_hold    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                setting = (ph == 1) ? 16'h0000 :
                          (ph == 2) ? 16'hFFFF :
                          (ph == 3) ? 16'h8000 : 16'($urandom);
                write_first_block(setting);
            end
            case (ph)
                0:
                begin
                    offer_get(16'h0000);
                    offer_get(16'h0000);
                    offer_get(16'hFFFF);
                    offer_get(16'h5555);
                    offer_get(16'hAAAA);
                    offer_put(6'd0);
                    offer_put(6'd0);
                    offer_put(6'd0);
                    offer_put(6'd63);
                    offer_get(16'hFFFF);
                    offer_get(16'd64);
                    offer_request(OP_UNUSED, 16'h0000, 6'd0);
                    offer_put(6'd1);
                    offer_clear();
                    offer_put(6'd1);
                    offer_get(16'h1234);
                    offer_put(6'h2A);
                    offer_put(6'd0);
                    offer_get(16'd63);
                    offer_request(OP_UNUSED, 16'hFFFF, 6'h3F);
                end
                1:
                    long_hold <= 1'b1;
                3:
                begin
                    // drive one slot past the count limit, then back off
                    ino = 16'($urandom);
                    offer_clear();
                    for (k = 0; k < 257; k++)
                        offer_get(ino);
                    offer_put(6'd0);
                    offer_get(ino);
                    offer_get(ino);
                    for (k = 0; k < 3; k++)
                        offer_put(6'd0);
                end
                2, 4:
                    fill_slot_table();
                default:
                    ;
            endcase
            mixed_traffic(MIX_ITEMS);
            wait_for_drain();
        end

        $display("summary: %0d requests and %0d replies over %0d inode area bases",
                 items_sent, results_taken, PHASES);
        $display("summary: corners, full table, saturated count, long output hold-off");
        if (mismatches == 0 && pending == 0)
            $display("tb_refcounted_inode_slot_table: done, clean");
        else
            $display("tb_refcounted_inode_slot_table: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/ris_pkg.sv
sv/ris_cell.sv
sv/ris_locate.sv
sv/refcounted_inode_slot_table.sv
bench/refcounted_inode_slot_table_checker.sv
bench/tb_refcounted_inode_slot_table.sv
